// File: rtl/floyd_steinberg_dither_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the error-diffusion dither block
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FLOYD_STEINBERG_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_DITHER_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define FSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FSD_ASSERT_IMPL(lbl, ante, cons, msg)
`define FSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// Dither package
// Shared constants, types and arithmetic helpers of the dither block.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // Widest row the column store supports.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int GRAY_W   = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int CNT_W    = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ?
                            $clog2(MAX_WIDTH + 1) : WIDTH_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  // Error shares: 7/16 right, 1/16 lower right, 5/16 below, 3/16 lower left.
  localparam int RIGHT_W = 7;
  localparam int LR_W    = 4;
  localparam int DOWN_W  = 7;
  localparam int LL_W    = 6;

  localparam logic [GRAY_W-1:0] THRESHOLD = 8'd127;
  localparam logic [GRAY_W-1:0] WHITE     = 8'd255;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified pixel, passed from the front to the back.
  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [COL_W-1:0]  col;
    logic              last_col;
    logic              last_row;
    logic              spread;
  } pix_item_t;

  // Column store entry for the upper-left and upper shares.
  typedef struct packed {
    logic signed [LR_W-1:0]   ul;
    logic signed [DOWN_W-1:0] up;
  } entry_a_t;

  // Adds a signed share to a gray value and clamps to 0..255.
  function automatic logic [GRAY_W-1:0] sat_add(input logic [GRAY_W-1:0] v,
                                                input logic signed [7:0] e);
    logic signed [9:0] t;
    t = $signed({2'b00, v}) + $signed({{2{e[7]}}, e});
    if (t > 10'sd255) begin
      return WHITE;
    end
    if (t < 10'sd0) begin
      return '0;
    end
    return t[7:0];
  endfunction

  // Signed divide by 16, truncating toward zero.
  function automatic logic signed [7:0] div16_tz(input logic signed [11:0] x);
    logic signed [11:0] q;
    q = x >>> 4;
    if (x[11] && (x[3:0] != 4'd0)) begin
      q = q + 12'sd1;
    end
    return q[7:0];
  endfunction

endpackage

// File: rtl/fsd_ifs.sv
// ----------------------------------------------------------------------------
// Dither channel interfaces
// Pixel input, dithered result and configuration write channels.
// ----------------------------------------------------------------------------
interface fsd_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [fsd_pkg::GRAY_W-1:0] pixel_gray;

  modport source (output valid, output pixel_gray, input ready);
  modport sink   (input valid, input pixel_gray, output ready);
endinterface

interface fsd_result_if;
  logic valid;
  logic ready;
  logic pixel_on;
  logic end_of_row;
  logic end_of_frame;

  modport source (output valid, output pixel_on, output end_of_row,
                  output end_of_frame, input ready);
  modport sink   (input valid, input pixel_on, input end_of_row,
                  input end_of_frame, output ready);
endinterface

interface fsd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fsd_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [fsd_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/fsd_front.sv
// ----------------------------------------------------------------------------
// Dither front end
// Accepts pixels, tracks column and row, and classifies each pixel.
// ----------------------------------------------------------------------------
module fsd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fsd_pkg::WIDTH_W-1:0]   image_width,
  input  logic [fsd_pkg::HEIGHT_W-1:0]  image_height,
  input  logic                          clr_busy,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsd_pkg::GRAY_W-1:0]    in_pixel_gray,
  output logic                          push_valid,
  input  logic                          push_ready,
  output fsd_pkg::pix_item_t            push_item
);

  logic [fsd_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [fsd_pkg::HEIGHT_W-1:0] row_r, row_nxt;
  logic [fsd_pkg::CNT_W-1:0]    w_ext, w_eff, col_p1;
  logic [fsd_pkg::HEIGHT_W:0]   h_eff, row_p1;
  logic                         last_col, last_row, accept;

  // Out-of-range sizes are clamped: zero acts as one, wide rows as the store size.
  always_comb begin
    w_ext = fsd_pkg::CNT_W'(image_width);
    if (w_ext == '0) begin
      w_eff = fsd_pkg::CNT_W'(1);
    end else if (w_ext > fsd_pkg::CNT_W'(fsd_pkg::MAX_WIDTH)) begin
      w_eff = fsd_pkg::CNT_W'(fsd_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (image_height == '0) ? (fsd_pkg::HEIGHT_W+1)'(1)
                                 : {1'b0, image_height};
    col_p1   = fsd_pkg::CNT_W'(col_r) + fsd_pkg::CNT_W'(1);
    row_p1   = {1'b0, row_r} + (fsd_pkg::HEIGHT_W+1)'(1);
    last_col = (col_p1 >= w_eff);
    last_row = (row_p1 >= h_eff);
  end

  assign in_ready   = push_ready && !clr_busy;
  assign push_valid = in_valid && !clr_busy;
  assign accept     = in_valid && in_ready;

  always_comb begin
    push_item.gray     = in_pixel_gray;
    push_item.col      = col_r;
    push_item.last_col = last_col;
    push_item.last_row = last_row;
    push_item.spread   = !last_row && !last_col && (col_r != '0);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_p1[fsd_pkg::HEIGHT_W-1:0];
      end else begin
        col_nxt = col_p1[fsd_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: rtl/fsd_queue.sv
// ----------------------------------------------------------------------------
// Dither item queue
// Short FIFO that decouples the classifying front from the arithmetic back.
// ----------------------------------------------------------------------------
module fsd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fsd_pkg::pix_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fsd_pkg::pix_item_t pop_item
);

  fsd_pkg::pix_item_t           slot_r [fsd_pkg::QUEUE_DEPTH];
  logic [fsd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [fsd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [fsd_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != fsd_pkg::QCNT_W'(fsd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fsd_pkg::QPTR_W'(fsd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + fsd_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fsd_pkg::QPTR_W'(fsd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + fsd_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + fsd_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - fsd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/fsd_back.sv
// ----------------------------------------------------------------------------
// Dither back end
// Column error store, diffusion arithmetic and the result register.
// ----------------------------------------------------------------------------
module fsd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  fsd_pkg::pix_item_t pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_pixel_on,
  output logic               out_end_of_row,
  output logic               out_end_of_frame,
  output logic               clr_busy
);

  // Store A holds the upper-left and upper shares, store B the upper-right share.
  fsd_pkg::entry_a_t                  mem_a [fsd_pkg::MAX_WIDTH];
  logic signed [fsd_pkg::LL_W-1:0]    mem_b [fsd_pkg::MAX_WIDTH];

  logic                               clr_busy_r;
  logic [fsd_pkg::COL_W-1:0]          clr_addr_r;
  logic                               s0_valid_r;
  fsd_pkg::pix_item_t                 s0_item_r;
  fsd_pkg::entry_a_t                  rd_a_r, a_byp_data_r, cur_a;
  logic signed [fsd_pkg::LL_W-1:0]    rd_b_r, b_byp_data_r, cur_b;
  logic                               a_byp_r, b_byp_r;
  logic signed [fsd_pkg::RIGHT_W-1:0] carry_r, carry_nxt;
  logic signed [fsd_pkg::LR_W-1:0]    held_r, held_nxt;
  logic                               pend_valid_r;
  logic [fsd_pkg::COL_W-1:0]          pend_addr_r;
  logic                               out_valid_r, pixel_on_r, eor_r, eof_r;

  logic                               s0_adv, pop;
  logic [fsd_pkg::GRAY_W-1:0]         v1, v2, v3, v;
  logic                               on;
  logic signed [9:0]                  err10;
  logic signed [7:0]                  err;
  logic signed [11:0]                 e12;
  logic signed [7:0]                  q_right, q_lr, q_down, q_ll;
  logic signed [fsd_pkg::RIGHT_W-1:0] a_share;
  logic signed [fsd_pkg::LR_W-1:0]    b_share;
  logic signed [fsd_pkg::DOWN_W-1:0]  c_share;
  logic signed [fsd_pkg::LL_W-1:0]    d_share;

  logic                               we_a, we_b;
  logic [fsd_pkg::COL_W-1:0]          wa_a, wa_b;
  fsd_pkg::entry_a_t                  wd_a;
  logic signed [fsd_pkg::LL_W-1:0]    wd_b;
  logic                               hit_a, zero_b, hit_b;

  assign s0_adv    = s0_valid_r && (!out_valid_r || out_ready);
  assign pop_ready = !clr_busy_r && (!s0_valid_r || s0_adv);
  assign pop       = pop_valid && pop_ready;
  assign clr_busy  = clr_busy_r;

  assign cur_a = a_byp_r ? a_byp_data_r : rd_a_r;
  assign cur_b = b_byp_r ? b_byp_data_r : rd_b_r;

  // Shares are added in a fixed order, each clamped to the gray range.
  always_comb begin
    v1  = fsd_pkg::sat_add(s0_item_r.gray, 8'(cur_a.ul));
    v2  = fsd_pkg::sat_add(v1, 8'(cur_a.up));
    v3  = fsd_pkg::sat_add(v2, 8'(cur_b));
    v   = fsd_pkg::sat_add(v3, 8'(carry_r));
    on  = (v > fsd_pkg::THRESHOLD);
    err10 = on ? ($signed({2'b00, v}) - $signed({2'b00, fsd_pkg::WHITE}))
               : $signed({2'b00, v});
    err = err10[7:0];
    e12 = 12'(err);
    q_right = fsd_pkg::div16_tz((e12 <<< 3) - e12);
    q_lr    = fsd_pkg::div16_tz(e12);
    q_down  = fsd_pkg::div16_tz((e12 <<< 2) + e12);
    q_ll    = fsd_pkg::div16_tz((e12 <<< 1) + e12);
    if (s0_item_r.spread) begin
      a_share = q_right[fsd_pkg::RIGHT_W-1:0];
      b_share = q_lr[fsd_pkg::LR_W-1:0];
      c_share = q_down[fsd_pkg::DOWN_W-1:0];
      d_share = q_ll[fsd_pkg::LL_W-1:0];
    end else begin
      a_share = '0;
      b_share = '0;
      c_share = '0;
      d_share = '0;
    end
  end

  // The upper-right entry of a column is zeroed when the column is consumed,
  // and that zero is held pending until the next pixel either replaces it with
  // its lower-left share or writes it back as zero.
  always_comb begin
    if (clr_busy_r) begin
      we_a = 1'b1;
      wa_a = clr_addr_r;
      wd_a = '0;
      we_b = 1'b1;
      wa_b = clr_addr_r;
      wd_b = '0;
    end else begin
      we_a    = s0_adv;
      wa_a    = s0_item_r.col;
      wd_a.ul = held_r;
      wd_a.up = c_share;
      we_b    = s0_adv && pend_valid_r;
      wa_b    = pend_addr_r;
      wd_b    = d_share;
    end
  end

  // Forwarding for a read that meets a write or a pending zero of the same column.
  always_comb begin
    hit_a  = s0_adv && (s0_item_r.col == pop_item.col);
    zero_b = s0_adv ? (s0_item_r.col == pop_item.col)
                    : (pend_valid_r && (pend_addr_r == pop_item.col));
    hit_b  = s0_adv && pend_valid_r && (pend_addr_r == pop_item.col);
  end

  always_comb begin
    carry_nxt = carry_r;
    held_nxt  = held_r;
    if (s0_adv) begin
      carry_nxt = s0_item_r.last_col ? '0 : a_share;
      held_nxt  = s0_item_r.last_col ? '0 : b_share;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    if (pop) begin
      rd_a_r <= mem_a[pop_item.col];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wa_b] <= wd_b;
    end
    if (pop) begin
      rd_b_r <= mem_b[pop_item.col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r   <= 1'b1;
      clr_addr_r   <= '0;
      s0_valid_r   <= 1'b0;
      carry_r      <= '0;
      held_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + fsd_pkg::COL_W'(1);
        if (clr_addr_r == fsd_pkg::COL_W'(fsd_pkg::MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        s0_valid_r <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_r <= 1'b0;
      end
      carry_r <= carry_nxt;
      held_r  <= held_nxt;
      if (s0_adv) begin
        pend_valid_r <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s0_item_r    <= pop_item;
      a_byp_r      <= hit_a;
      a_byp_data_r <= wd_a;
      b_byp_r      <= zero_b || hit_b;
      b_byp_data_r <= zero_b ? '0 : wd_b;
    end
    if (s0_adv) begin
      pend_addr_r <= s0_item_r.col;
      pixel_on_r  <= on;
      eor_r       <= s0_item_r.last_col;
      eof_r       <= s0_item_r.last_col && s0_item_r.last_row;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_on     = pixel_on_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;

endmodule

// File: rtl/floyd_steinberg_dither.sv
// ----------------------------------------------------------------------------
// Floyd-Steinberg error-diffusion dither
// Streaming dither of 8-bit gray pixels in raster order to one bit per pixel.
// Throughput is one pixel per clock unless the output stalls or the store is
// being cleared. An accepted pixel passes the queue and the stage register;
// its result is presented from the output register. The rate is set by the
// right-neighbor error loop in the back end, which adds the carried share,
// thresholds and computes the next carry combinationally, and by the single
// write port of each column store. After reset the store is cleared over all
// 1024 entries (one entry per cycle) and no pixel is accepted meanwhile;
// configuration writes are taken at any time but must only be issued while
// the block is idle. Width and height take effect on the next pixel.
// ----------------------------------------------------------------------------
`include "floyd_steinberg_dither_assert.svh"

module floyd_steinberg_dither (
  input  logic          clk,
  input  logic          rst_n,
  fsd_pixel_if.sink     in_chan,
  fsd_result_if.source  out_chan,
  fsd_cfg_if.sink       cfg_chan
);

  logic [fsd_pkg::WIDTH_W-1:0]  image_width_r;
  logic [fsd_pkg::HEIGHT_W-1:0] image_height_r;
  logic                         clr_busy;
  logic                         push_valid, push_ready, pop_valid, pop_ready;
  fsd_pkg::pix_item_t           push_item, pop_item;
  logic                         cfg_wr;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= fsd_pkg::WIDTH_RESET;
      image_height_r <= fsd_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_chan.reg_index)
        fsd_pkg::CFG_IMAGE_WIDTH: begin
          image_width_r <= cfg_chan.wr_data[fsd_pkg::WIDTH_W-1:0];
        end
        fsd_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_chan.wr_data[fsd_pkg::HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .image_width   (image_width_r),
    .image_height  (image_height_r),
    .clr_busy      (clr_busy),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_pixel_gray (in_chan.pixel_gray),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  fsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_pixel_on     (out_chan.pixel_on),
    .out_end_of_row   (out_chan.end_of_row),
    .out_end_of_frame (out_chan.end_of_frame),
    .clr_busy         (clr_busy)
  );

  // A frame can only end on the last pixel of a row.
  `FSD_ASSERT_IMPL(a_eof_eor, out_chan.valid && out_chan.end_of_frame, out_chan.end_of_row, "lone eof")
  // No result may be presented while the column store is being cleared.
  `FSD_ASSERT_IMPL(a_no_result_in_clear, clr_busy, !out_chan.valid, "result during store clear")
  // The clearing pass must start when reset is released.
  `FSD_ASSERT_NEXT(a_clear_after_reset, $rose(rst_n), clr_busy, "store clear did not run")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Dither block testbench
// Streams gray pixels through the error-diffusion dither under changing frame
// sizes and random back-pressure, and checks every output bit against a
// cycle-free model of the diffusion kept inside the bench or a typed table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT    = 6000;
  localparam int HOLD_CYCLES    = 200;
  localparam int ITEMS_PER_PASS = 160;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic pixel_on;
    logic end_of_row;
    logic end_of_frame;
  } dither_out_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef enum int {
    STYLE_ANY,
    STYLE_THRESHOLD,
    STYLE_EXTREME,
    STYLE_NEAR_RAIL,
    STYLE_FLAT
  } gray_style_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] width_val;
    logic [15:0] height_val;
    logic [7:0]  gray;
    logic        typed;
    dither_out_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  // Pixel rows with the typed flag set carry a result that follows from
  // zero pending errors and a zero carry; the rest go through the model.
  directed_row_t directed_table [DIRECTED_ROWS] = '{
    '{ROW_PIX, 16'd0,      16'd0,      8'd0,   1'b1, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd255, 1'b1, 3'b100},
    '{ROW_PIX, 16'd0,      16'd0,      8'd127, 1'b1, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd128, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd255, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd0,   1'b0, 3'b000},
    // Zero width and zero height mid-row: both act as one.
    '{ROW_CFG, 16'd0,      16'd0,      8'd0,   1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd200, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd0,   1'b1, 3'b011},
    '{ROW_PIX, 16'd0,      16'd0,      8'd255, 1'b1, 3'b111},
    '{ROW_PIX, 16'd0,      16'd0,      8'd127, 1'b1, 3'b011},
    '{ROW_PIX, 16'd0,      16'd0,      8'd128, 1'b1, 3'b111},
    // All ones: the width field reads 2047, which acts as the widest row.
    '{ROW_CFG, 16'hFFFF,   16'hFFFF,   8'd0,   1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd255, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd0,   1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd64,  1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd192, 1'b0, 3'b000},
    // Shrinking the row below the current column ends the row at once.
    '{ROW_CFG, 16'd3,      16'd2,      8'd0,   1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd100, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd255, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd0,   1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd255, 1'b0, 3'b000},
    // Upper data bits lie outside the width register and are dropped.
    '{ROW_CFG, 16'hF802,   16'd1,      8'd0,   1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd130, 1'b0, 3'b000},
    '{ROW_PIX, 16'd0,      16'd0,      8'd90,  1'b0, 3'b000}
  };

  int send_pct_by_pass [3] = '{14, 80, 0};
  int recv_pct_by_pass [3] = '{80, 14, 0};

  logic clk = 1'b0;
  logic rst_n;

  fsd_pixel_if  pix_if ();
  fsd_result_if res_if ();
  fsd_cfg_if    cfg_if ();

  floyd_steinberg_dither u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_if),
    .out_chan (res_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Diffusion model state.
  logic [fsd_pkg::WIDTH_W-1:0]  model_width  = fsd_pkg::WIDTH_RESET;
  logic [fsd_pkg::HEIGHT_W-1:0] model_height = fsd_pkg::HEIGHT_RESET;
  int          ul_share [fsd_pkg::MAX_WIDTH];
  int          up_share [fsd_pkg::MAX_WIDTH];
  int          ur_share [fsd_pkg::MAX_WIDTH];
  int          carry_right = 0;
  int          held_lower_right = 0;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  dither_out_t awaited_pixels [$];
  dither_out_t oldest_pixel;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int mismatch_count = 0;

  function automatic int clamp_gray(input int x);
    if (x > 255) begin
      return 255;
    end
    if (x < 0) begin
      return 0;
    end
    return x;
  endfunction

  function automatic dither_out_t dither_pixel(input logic [7:0] gray);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic        last_c;
    logic        last_r;
    logic        spread;
    logic        on;
    int          level;
    int          err;
    int          to_right;
    int          to_lr;
    int          to_down;
    int          to_ll;
    dither_out_t res;

    w = model_width;
    if (w == 0) begin
      w = 1;
    end
    if (w > fsd_pkg::MAX_WIDTH) begin
      w = fsd_pkg::MAX_WIDTH;
    end
    h = (model_height == 0) ? 1 : model_height;
    c = (col_cnt >= fsd_pkg::MAX_WIDTH) ? fsd_pkg::MAX_WIDTH - 1 : col_cnt;
    last_c = (c + 1 >= w);
    last_r = (row_cnt + 1 >= h);

    level = clamp_gray(int'(gray) + ul_share[c]);
    level = clamp_gray(level + up_share[c]);
    level = clamp_gray(level + ur_share[c]);
    level = clamp_gray(level + carry_right);
    on    = (level > 127);
    err   = on ? level - 255 : level;

    spread   = !last_r && (c != 0) && !last_c;
    to_right = 0;
    to_lr    = 0;
    to_down  = 0;
    to_ll    = 0;
    if (spread) begin
      to_right = (err * 7) / 16;
      to_lr    = err / 16;
      to_down  = (err * 5) / 16;
      to_ll    = (err * 3) / 16;
    end

    // The column entry is used up and refilled for the row below.
    ul_share[c] = held_lower_right;
    up_share[c] = to_down;
    ur_share[c] = 0;
    if (spread) begin
      ur_share[c - 1] = to_ll;
    end
    held_lower_right = to_lr;
    carry_right      = to_right;

    res.pixel_on     = on;
    res.end_of_row   = last_c;
    res.end_of_frame = last_c && last_r;

    if (last_c) begin
      col_cnt          = 0;
      carry_right      = 0;
      held_lower_right = 0;
      row_cnt          = last_r ? 0 : ((row_cnt + 1) & 32'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      return 16'($urandom_range(8, 1));
    end
    if (sel < 70) begin
      return 16'($urandom_range(40, 9));
    end
    if (sel < 75) begin
      return 16'd0;
    end
    if (sel < 82) begin
      return 16'(fsd_pkg::MAX_WIDTH);
    end
    if (sel < 86) begin
      return 16'd2047;
    end
    if (sel < 92) begin
      return 16'($urandom_range(2046, fsd_pkg::MAX_WIDTH + 1));
    end
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] pick_height();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      return 16'($urandom_range(6, 1));
    end
    if (sel < 72) begin
      return 16'($urandom_range(20, 7));
    end
    if (sel < 82) begin
      return 16'd0;
    end
    if (sel < 92) begin
      return 16'hFFFF;
    end
    return 16'($urandom());
  endfunction

  function automatic logic [7:0] pick_gray(input gray_style_t style, input logic [7:0] level);
    int shade;
    case (style)
      STYLE_THRESHOLD: return 8'($urandom_range(143, 112));
      STYLE_EXTREME:   return $urandom_range(1) ? 8'd255 : 8'd0;
      STYLE_NEAR_RAIL: begin
        return $urandom_range(1) ? 8'($urandom_range(12)) : 8'($urandom_range(255, 243));
      end
      STYLE_FLAT: begin
        shade = int'(level) + int'($urandom_range(6)) - 3;
        return 8'(clamp_gray(shade));
      end
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] gray, input logic typed, input dither_out_t want);
    dither_out_t predicted;
    if ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pix_if.valid      <= 1'b1;
    pix_if.pixel_gray <= gray;
    do @(posedge clk); while (!pix_if.ready);
    predicted = dither_pixel(gray);
    awaited_pixels.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_pixels.size() != 0);
  endtask

  // Both registers are written back to back with valid held high.
  task automatic set_config(input logic [15:0] width_val, input logic [15:0] height_val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= fsd_pkg::CFG_IMAGE_WIDTH;
    cfg_if.wr_data   <= width_val;
    do @(posedge clk); while (!cfg_if.ready);
    model_width      = width_val[fsd_pkg::WIDTH_W-1:0];
    cfg_if.reg_index <= fsd_pkg::CFG_IMAGE_HEIGHT;
    cfg_if.wr_data   <= height_val;
    do @(posedge clk); while (!cfg_if.ready);
    model_height     = height_val;
    cfg_if.valid     <= 1'b0;
  endtask

  task automatic run_frame_burst(inout int sent);
    logic [15:0] width_val;
    logic [15:0] height_val;
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned count;
    gray_style_t style;
    logic [7:0]  level;
    width_val  = pick_width();
    height_val = pick_height();
    eff_w = width_val[fsd_pkg::WIDTH_W-1:0];
    if (eff_w == 0) begin
      eff_w = 1;
    end
    if (eff_w > fsd_pkg::MAX_WIDTH) begin
      eff_w = fsd_pkg::MAX_WIDTH;
    end
    eff_h = (height_val == 0) ? 1 : height_val;
    // Small frames are sent whole; large ones only in part, so the counters
    // carry over into the next size.
    count = (eff_w * eff_h <= 80) ? eff_w * eff_h * $urandom_range(2, 1)
                                  : $urandom_range(60, 10);
    style = gray_style_t'($urandom_range(4));
    level = 8'($urandom());
    wait_drained();
    set_config(width_val, height_val);
    repeat (count) begin
      send_pixel(pick_gray(style, level), 1'b0, '0);
    end
    sent += count;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (awaited_pixels.size() == 0) begin
        $error("result transaction with nothing awaited");
        mismatch_count++;
      end else begin
        oldest_pixel = awaited_pixels.pop_front();
        if (res_if.pixel_on !== oldest_pixel.pixel_on) begin
          $error("pixel_on: expected %0b, got %0b", oldest_pixel.pixel_on, res_if.pixel_on);
          mismatch_count++;
        end
        if (res_if.end_of_row !== oldest_pixel.end_of_row) begin
          $error("end_of_row: expected %0b, got %0b",
                 oldest_pixel.end_of_row, res_if.end_of_row);
          mismatch_count++;
        end
        if (res_if.end_of_frame !== oldest_pixel.end_of_frame) begin
          $error("end_of_frame: expected %0b, got %0b",
                 oldest_pixel.end_of_frame, res_if.end_of_frame);
          mismatch_count++;
        end
      end
    end
  end

  // The limit covers the clearing pass after reset and the long output hold.
  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    rst_n             <= 1'b0;
    pix_if.valid      <= 1'b0;
    pix_if.pixel_gray <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.reg_index  <= fsd_pkg::CFG_IMAGE_WIDTH;
    cfg_if.wr_data    <= '0;
    send_idle_pct = send_pct_by_pass[0];
    recv_idle_pct <= recv_pct_by_pass[0];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_table[i]) begin
      if (directed_table[i].kind == ROW_CFG) begin
        wait_drained();
        set_config(directed_table[i].width_val, directed_table[i].height_val);
      end else begin
        send_pixel(directed_table[i].gray, directed_table[i].typed, directed_table[i].want);
      end
    end

    for (int pass = 0; pass < 3; pass++) begin
      send_idle_pct = send_pct_by_pass[pass];
      recv_idle_pct <= recv_pct_by_pass[pass];
      sent = 0;
      if (pass == 2) begin
        // Hold the output off while pixels keep coming, so the block backs up.
        hold_requests <= hold_requests + 1;
        repeat (40) begin
          send_pixel(8'($urandom()), 1'b0, '0);
        end
        sent = 40;
      end
      while (sent < ITEMS_PER_PASS) begin
        run_frame_burst(sent);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: floyd_steinberg_dither.f
+incdir+rtl
rtl/fsd_pkg.sv
rtl/fsd_ifs.sv
rtl/fsd_front.sv
rtl/fsd_queue.sv
rtl/fsd_back.sv
rtl/floyd_steinberg_dither.sv
tb/tb_top.sv
